// ===== rtl/core/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg: shared definitions for the full-convolution FIR filter
// Field widths, defaults, command codes and the pipeline tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_TAPS_DEF    = 33;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int RESULT_BITS     = 38;
  localparam int TAP_COUNT_BITS  = 6;
  localparam int TAP_INDEX_BITS  = 6;

  localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 6'd33;

  // Command codes carried in the cmd field
  localparam logic CMD_LOAD_TAP = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;

  // Control that travels alongside each sum through the pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } fir_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/fir_if.sv =====
// ----------------------------------------------------------------------------
// fir_if: stream channels of the FIR filter
// Input channel (tap loads and samples) and result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fir_in_if
  import fir_pkg::*;
  #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);

  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [TAP_INDEX_BITS-1:0]     tap_index;
  logic signed [SAMPLE_BITS-1:0] tap_value;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, cmd, tap_index, tap_value, sample, last_sample,
                  input ready);
  modport sink   (input valid, cmd, tap_index, tap_value, sample, last_sample,
                  output ready);

endinterface

interface fir_out_if
  import fir_pkg::*;
  ();

  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] result;
  logic                          last_result;

  modport source (output valid, result, last_result, input ready);
  modport sink   (input valid, result, last_result, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/fir_front.sv =====
// ----------------------------------------------------------------------------
// fir_front: tap store, delay line, tail flush and product register
// Takes input transactions, runs the tail flush, registers all products.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_front
  import fir_pkg::*;
  #(
    parameter int NUM_TAPS    = NUM_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
  )
  (
    input  wire logic                          clk,
    input  wire logic                          rst,
    input  wire logic                          enable,
    input  wire logic [TAP_COUNT_BITS-1:0]     tap_count,
    fir_in_if.sink                             in_ch,
    output logic signed [RESULT_BITS-1:0]      prod [NUM_TAPS],
    output fir_tag_t                           tag
  );

  localparam int TW = $clog2(NUM_TAPS + 1);
  localparam int DL = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;

  logic signed [SAMPLE_BITS-1:0] tap_store [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] delay     [DL];
  logic [TW-1:0]                 rem;        // tail outputs still to go
  logic [TW-1:0]                 taps_eff;
  logic                          flushing;
  logic                          accepted;
  logic                          load_step;
  logic                          sample_step;
  logic                          flush_step;
  logic                          step;
  logic                          mark;
  logic                          clear;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [RESULT_BITS-1:0] prod_next [NUM_TAPS];

  // Taps in use: zero acts as one, beyond the store acts as the full store
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TW'(1);
    end else if (int'(tap_count) > NUM_TAPS) begin
      taps_eff = TW'(NUM_TAPS);
    end else begin
      taps_eff = TW'(tap_count);
    end
  end

  // Handshake and step decode
  assign flushing    = (rem != '0);
  assign in_ch.ready = enable && !flushing;
  assign accepted    = in_ch.valid && in_ch.ready;
  assign load_step   = accepted && (in_ch.cmd == CMD_LOAD_TAP);
  assign sample_step = accepted && (in_ch.cmd == CMD_SAMPLE);
  assign flush_step  = flushing && enable;
  assign step        = sample_step || flush_step;
  assign x           = flushing ? '0 : in_ch.sample;

  // Final output of a block: tail end, or a marked sample with one tap
  assign mark  = flushing ? (rem == TW'(1))
                          : (in_ch.last_sample && (taps_eff == TW'(1)));
  assign clear = step && mark;

  // Products of the window against the taps; unused taps give zero
  always_comb begin
    logic signed [2*SAMPLE_BITS-1:0] p;
    for (int j = 0; j < NUM_TAPS; j++) begin
      if (j == 0) begin
        p = tap_store[j] * x;
      end else begin
        p = tap_store[j] * delay[j-1];
      end
      prod_next[j] = (TW'(j) < taps_eff) ? RESULT_BITS'(p) : '0;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (enable) begin
      prod <= prod_next;
    end
  end

  // Tag register; the last mark only rides on a real output
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else if (enable) begin
      tag.vld  <= step;
      tag.last <= clear;
    end
  end

  // Tail flush counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (flush_step) begin
      rem <= rem - TW'(1);
    end else if (sample_step && in_ch.last_sample && (taps_eff != TW'(1))) begin
      rem <= taps_eff - TW'(1);
    end
  end

  // Delay line: newest first, cleared after the block's final output
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DL; j++) begin
        delay[j] <= '0;
      end
    end else if (clear) begin
      for (int j = 0; j < DL; j++) begin
        delay[j] <= '0;
      end
    end else if (step) begin
      delay[0] <= x;
      for (int j = 1; j < DL; j++) begin
        delay[j] <= delay[j-1];
      end
    end
  end

  // Tap store; an index past the store matches no entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        tap_store[j] <= '0;
      end
    end else if (load_step) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        if (in_ch.tap_index == TAP_INDEX_BITS'(j)) begin
          tap_store[j] <= in_ch.tap_value;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fir_tree.sv =====
// ----------------------------------------------------------------------------
// fir_tree: registered adder tree
// Sums the registered products pairwise, one register level per add level.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_tree
  import fir_pkg::*;
  #(
    parameter int NUM_TAPS = NUM_TAPS_DEF
  )
  (
    input  wire logic                          clk,
    input  wire logic                          rst,
    input  wire logic                          enable,
    input  wire logic signed [RESULT_BITS-1:0] prod [NUM_TAPS],
    input  wire fir_tag_t                      in_tag,
    output logic signed [RESULT_BITS-1:0]      sum,
    output fir_tag_t                           out_tag
  );

  localparam int LEVELS = $clog2(NUM_TAPS);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int INNER  = (LEAVES > 1) ? LEAVES - 1 : 1;
  localparam int TAGS   = (LEVELS > 0) ? LEVELS : 1;

  // Heap layout: node n has children 2n+1 and 2n+2, leaves at the end
  logic signed [RESULT_BITS-1:0] node_val [NODES];
  logic signed [RESULT_BITS-1:0] node_q   [INNER];
  fir_tag_t                      tag_pipe [TAGS];

  genvar n;
  generate
    for (n = 0; n < NODES; n++) begin : g_node
      if (n >= LEAVES - 1) begin : g_leaf
        if (n - (LEAVES - 1) < NUM_TAPS) begin : g_used
          assign node_val[n] = prod[n - (LEAVES - 1)];
        end else begin : g_pad
          assign node_val[n] = '0;
        end
      end else begin : g_inner
        assign node_val[n] = node_q[n];
      end
    end
  endgenerate

  // Inner node registers
  always_ff @(posedge clk) begin
    if (enable) begin
      for (int i = 0; i < LEAVES - 1; i++) begin
        node_q[i] <= node_val[2*i+1] + node_val[2*i+2];
      end
    end
  end

  // Tag follows the sum level by level
  generate
    if (LEVELS > 0) begin : g_tags
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int l = 0; l < LEVELS; l++) begin
            tag_pipe[l] <= '0;
          end
        end else if (enable) begin
          tag_pipe[0] <= in_tag;
          for (int l = 1; l < LEVELS; l++) begin
            tag_pipe[l] <= tag_pipe[l-1];
          end
        end
      end
      assign out_tag = tag_pipe[LEVELS-1];
    end else begin : g_no_tags
      assign out_tag = in_tag;
    end
  endgenerate

  assign sum = node_val[0];

endmodule

`default_nettype wire

// ===== rtl/core/fir_full_convolution.sv =====
// ----------------------------------------------------------------------------
// fir_full_convolution: streaming FIR filter with full linear convolution
// Tap loads, samples, tail flush and exact Q.30 sums of products.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while neither the tail flush nor
// a stalled result channel holds it: a tap load (cmd 0) writes one
// coefficient, a sample (cmd 1) yields one exact 38-bit sum of products. A
// sample marked last is followed by one tail output per tap in use beyond
// the first (tap_count clamped to 1..NUM_TAPS), computed from zero input;
// input ready stays low until the tail is out. The final output carries
// last_result and the delay line starts the next block clean. A sample
// passes through the product register and then the registered adder tree;
// a stalled result channel stalls the whole pipeline. tap_count must be
// written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_full_convolution
  import fir_pkg::*;
  #(
    parameter int NUM_TAPS    = NUM_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
  )
  (
    input  wire logic                      clk,
    input  wire logic                      rst,
    input  wire logic                      cfg_we,
    input  wire logic [TAP_COUNT_BITS-1:0] cfg_data,
    fir_in_if.sink                         in_ch,
    fir_out_if.source                      out_ch
  );

  logic [TAP_COUNT_BITS-1:0]     tap_count;
  logic                          enable;
  logic signed [RESULT_BITS-1:0] prod [NUM_TAPS];
  fir_tag_t                      prod_tag;
  fir_tag_t                      out_tag;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  // Pipeline advances unless a result waits at the output
  assign enable = !out_tag.vld || out_ch.ready;

  fir_front #(
    .NUM_TAPS    (NUM_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .tap_count (tap_count),
    .in_ch     (in_ch),
    .prod      (prod),
    .tag       (prod_tag)
  );

  fir_tree #(
    .NUM_TAPS (NUM_TAPS)
  ) u_tree (
    .clk     (clk),
    .rst     (rst),
    .enable  (enable),
    .prod    (prod),
    .in_tag  (prod_tag),
    .sum     (out_ch.result),
    .out_tag (out_tag)
  );

  assign out_ch.valid       = out_tag.vld;
  assign out_ch.last_result = out_tag.last;

  // A stalled result blocks new input transactions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while result channel is stalled");

  // Nothing comes out in the cycle right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  // The last mark never appears on an empty slot
  a_last_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_ch.last_result |-> out_ch.valid)
    else $error("last_result without a valid result");

endmodule

`default_nettype wire
